// ===== sv/gpfe_pkg.sv =====
package gpfe_pkg;

    localparam int NUM_PEAKS = 11;
    localparam int ROM_PEAKS = 11;
    localparam int NUM_LANES = (NUM_PEAKS < ROM_PEAKS) ? NUM_PEAKS : ROM_PEAKS;

    // Pipeline depths
    localparam int LANE_LAT = 18;
    localparam int SUM_LAT  = 3;
    localparam int TOT_LAT  = LANE_LAT + SUM_LAT;

    // Widths shared between lanes and summation
    localparam int AMP_W  = 18;
    localparam int RCP_W  = 18;
    localparam int EXP_W  = 31;
    localparam int TERM_W = AMP_W + EXP_W;

    typedef struct packed {
        logic [AMP_W-1:0]  amp;   // Q.16
        logic signed [15:0] mx;   // Q.10
        logic signed [15:0] my;   // Q.10
        logic [RCP_W-1:0]  rcpx;  // Q.16, 1/(2 sx^2)
        logic [RCP_W-1:0]  rcpy;  // Q.16, 1/(2 sy^2)
    } t_coef;

    localparam t_coef PEAK_ROM [ROM_PEAKS] = '{
        '{18'd27643,  -16'sd4915,  -16'sd4584, 18'd3087,   18'd200864},
        '{18'd93408,   16'sd7039,   16'sd4019, 18'd14110,  18'd170650},
        '{18'd54205,   16'sd1696,   16'sd7810, 18'd19667,  18'd5309},
        '{18'd100467,  16'sd4493,  -16'sd9735, 18'd8111,   18'd8485},
        '{18'd115409, -16'sd3205,  -16'sd3252, 18'd4409,   18'd8854},
        '{18'd29707,  -16'sd10050, -16'sd1610, 18'd4349,   18'd9505},
        '{18'd15676,  -16'sd6299,  -16'sd8601, 18'd3792,   18'd109515},
        '{18'd54814,   16'sd151,   -16'sd8615, 18'd4352,   18'd30290},
        '{18'd33161,  -16'sd9744,  -16'sd8758, 18'd240526, 18'd66664},
        '{18'd99549,   16'sd1025,   16'sd8199, 18'd3389,   18'd2974},
        '{18'd131072,  16'sd9216,  -16'sd1024, 18'd3641,   18'd3641}
    };

endpackage

// ===== sv/gpfe_lane.sv =====
module gpfe_lane
    import gpfe_pkg::*;
(
    input  logic                 i_clk,
    input  t_coef                i_coef,
    input  logic signed [15:0]   i_x_coord,
    input  logic signed [15:0]   i_y_coord,
    output logic [TERM_W-1:0]    o_term
);

    localparam logic [37:0] DIV3_M = 38'd349526;   // ceil(2^20 / 3)

    // floor(n / 3), exact for n below 2^19
    function automatic logic [17:0] div3(input logic [18:0] n);
        logic [37:0] prod;
        prod = {19'd0, n} * DIV3_M;
        return prod[37:20];
    endfunction

    function automatic logic [16:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

    function automatic logic [EXP_W-1:0] sq_q30(input logic [EXP_W-1:0] p);
        logic [61:0] prod;
        prod = {31'd0, p} * {31'd0, p} + 62'(1) * (62'd1 << 29);
        return prod[60:30];
    endfunction

    logic [16:0] r_dx, r_dy;
    logic [33:0] r_dx2, r_dy2;
    logic [48:0] r_ex, r_ey;
    logic [25:0] r_y4s, r_y5, r_y6, r_y7;
    logic [22:0] r_y2, r_y2_6, r_y2_7;
    logic [18:0] r_y3;
    logic [14:0] r_y4;
    logic [17:0] r_q6;
    logic [17:0] r_q24;
    logic [EXP_W-1:0] r_pa;
    logic [EXP_W-1:0] r_p;
    logic [EXP_W-1:0] r_sq [8];
    logic        r_far [14];
    logic [TERM_W-1:0] r_term;

    logic [50:0] n_tsum;
    logic [51:0] n_y2p;
    logic [48:0] n_y3p;
    logic [44:0] n_y4p;

    always_comb begin
        n_tsum = {2'd0, r_ex} + {2'd0, r_ey} + (51'd1 << 19);
        n_y2p  = {26'd0, r_y4s} * {26'd0, r_y4s} + (52'd1 << 29);
        n_y3p  = {26'd0, r_y2} * {23'd0, r_y5} + (49'd1 << 29);
        n_y4p  = {26'd0, r_y3} * {19'd0, r_y6} + (45'd1 << 29);
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= abs_diff(i_x_coord, i_coef.mx);
        r_dy   <= abs_diff(i_y_coord, i_coef.my);
        r_dx2  <= r_dx * r_dx;
        r_dy2  <= r_dy * r_dy;
        r_ex   <= {18'd0, r_dx2[30:0]} * {31'd0, i_coef.rcpx};
        r_ey   <= {18'd0, r_dy2[30:0]} * {31'd0, i_coef.rcpy};
        // exponent magnitude in Q.16, scaled down by 256 into Q.30
        r_y4s  <= {n_tsum[39:20], 6'd0};
        r_far[0] <= |n_tsum[50:40];
        r_y2   <= {1'b0, n_y2p[51:30]};
        r_y5   <= r_y4s;
        r_y3   <= n_y3p[48:30];
        r_y6   <= r_y5;
        r_y2_6 <= r_y2;
        r_y4   <= n_y4p[44:30];
        r_q6   <= div3(r_y3 >> 1);
        r_y7   <= r_y6;
        r_y2_7 <= r_y2_6;
        r_q24  <= div3({4'd0, r_y4} >> 3);
        r_pa   <= (31'd1 << 30) - {5'd0, r_y7} + {9'd0, r_y2_7[22:1]} - {13'd0, r_q6};
        r_p    <= r_pa + {13'd0, r_q24};
        r_sq[0] <= sq_q30(r_p);
        for (int k = 1; k < 8; k++) begin
            r_sq[k] <= sq_q30(r_sq[k-1]);
        end
        for (int k = 1; k < 14; k++) begin
            r_far[k] <= r_far[k-1];
        end
        r_term <= r_far[13] ? '0 : {{EXP_W{1'b0}}, i_coef.amp} * {{AMP_W{1'b0}}, r_sq[7]};
    end

    assign o_term = r_term;

endmodule

// ===== sv/gpfe_sum.sv =====
module gpfe_sum
    import gpfe_pkg::*;
(
    input  logic              i_clk,
    input  logic [TERM_W-1:0] i_term [NUM_LANES],
    output logic [15:0]       o_threat_value
);

    localparam int NUM_GRP = (NUM_LANES + 3) / 4;
    localparam int GRP_W   = TERM_W + 2;
    localparam int SUM_W   = TERM_W + 4;

    logic [GRP_W-1:0] r_grp [NUM_GRP];
    logic [SUM_W-1:0] r_sum;
    logic [15:0]      r_out;

    logic [GRP_W-1:0] n_grp [NUM_GRP];
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W+2:0] n_scaled;
    logic [20:0]      n_val;

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
        end
        // Group the lanes by four.
        for (int l = 0; l < NUM_LANES; l++) begin
            n_grp[l / 4] = n_grp[l / 4] + GRP_W'(i_term[l]);
        end
        n_sum = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_sum = n_sum + SUM_W'(r_grp[g]);
        end
        // 5 * sum, rounded from Q.46 to Q.10
        n_scaled = ({3'd0, r_sum} << 2) + {3'd0, r_sum} + ((SUM_W+3)'(1) << 35);
        n_val    = 21'd1024 + 21'(n_scaled[SUM_W+2:36]);
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NUM_GRP; g++) begin
            r_grp[g] <= n_grp[g];
        end
        r_sum <= n_sum;
        r_out <= (n_val > 21'd65535) ? 16'hFFFF : n_val[15:0];
    end

    assign o_threat_value = r_out;

endmodule

// ===== sv/gaussian_peak_field_eval_top.sv =====
// Channel   Ports                            Handshake
// -------   ------------------------------   ----------------------------------
// input     i_x_coord, i_y_coord             taken when i_start && !o_busy
// result    o_threat_value                   shown for one cycle with o_valid
//
// Every point passes 21 register stages, and its result strobe rises with its result.
// 18 stages sit in the per-peak lanes (difference, square, scale, exponent series,
// eight squarings, amplitude product) and 3 in the adder tree and output scaling.
// One point enters per cycle; o_busy stays low since the receiver cannot stall.
// Synchronous reset clears only the valid pipe; data stages run free.
module gaussian_peak_field_eval_top
    import gpfe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_x_coord,
    input  logic signed [15:0] i_y_coord,
    output logic               o_valid,
    output logic [15:0]        o_threat_value
);

    logic [TERM_W-1:0] w_term [NUM_LANES];
    logic [TOT_LAT-1:0] r_vld;

    // Advance the valid bit alongside each item's data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_start & ~o_busy};
        end
    end

    // One lane per peak; each lane holds its own constant coefficients.
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        gpfe_lane u_lane (
            .i_clk     (i_clk),
            .i_coef    (PEAK_ROM[i]),
            .i_x_coord (i_x_coord),
            .i_y_coord (i_y_coord),
            .o_term    (w_term[i])
        );
    end

    gpfe_sum u_sum (
        .i_clk          (i_clk),
        .i_term         (w_term),
        .o_threat_value (o_threat_value)
    );

    assign o_busy  = 1'b0;
    assign o_valid = r_vld[TOT_LAT-1];

`ifndef NO_ASSERTIONS
    a_vld_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, TOT_LAT))
        else $error("result strobe without a matching start");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_start, TOT_LAT) |-> !o_valid)
        else $error("result strobe appeared from an idle slot");
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_threat_value >= 16'd1024))
        else $error("threat value below its offset of one");
`endif

endmodule
